[rtl/core/tfsp_pkg.sv]
// shared widths, output codes and segment tags of the terrain file parser
`default_nettype none
package tfsp_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int CODE_W   = 2;
    localparam int MAP_W    = 17;
    localparam int WORD_W   = 16;

    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    localparam logic [CODE_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [CODE_W-1:0] ERR_BAD_NAME = 2'd0;
    localparam logic [CODE_W-1:0] ERR_NO_YPTS  = 2'd1;
    localparam logic [CODE_W-1:0] ERR_NO_ALTW  = 2'd2;

    localparam logic [63:0] TAG_NAME = 64'h5445_5252_4147_454E;
    localparam logic [63:0] TAG_TYPE = 64'h5445_5252_4149_4E20;
    localparam logic [31:0] TAG_SIZE = 32'h5349_5A45;
    localparam logic [31:0] TAG_XPTS = 32'h5850_5453;
    localparam logic [31:0] TAG_YPTS = 32'h5950_5453;
    localparam logic [31:0] TAG_ALTW = 32'h414C_5457;

endpackage
`default_nettype wire

[rtl/core/tfsp_in_if.sv]
// byte input channel of the terrain file parser
`default_nettype none
interface tfsp_in_if
    import tfsp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              first_byte;

    modport source (output valid, output in_byte, output first_byte, input ready);
    modport sink   (input valid, input in_byte, input first_byte, output ready);
endinterface
`default_nettype wire

[rtl/core/tfsp_out_if.sv]
// result channel of the terrain file parser
`default_nettype none
interface tfsp_out_if
    import tfsp_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        out_kind;
    logic [CODE_W-1:0]        error_code;
    logic [MAP_W-1:0]         map_cols;
    logic [MAP_W-1:0]         map_rows;
    logic [WORD_W-1:0]        height_scale;
    logic [WORD_W-1:0]        base_height;
    logic signed [WORD_W-1:0] height_sample;
    logic                     last_sample;

    modport source (
        output valid, output out_kind, output error_code, output map_cols,
        output map_rows, output height_scale, output base_height,
        output height_sample, output last_sample, input ready
    );
    modport sink (
        input valid, input out_kind, input error_code, input map_cols,
        input map_rows, input height_scale, input base_height,
        input height_sample, input last_sample, output ready
    );
endinterface
`default_nettype wire

[rtl/core/tfsp_sample_ctr.sv]
// row and column position of the sample stream, with final sample detect
`default_nettype none
module tfsp_sample_ctr #(
    parameter int DIM_WIDTH = 17
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_clear,
    input  wire                  i_step,
    input  wire [DIM_WIDTH-1:0]  i_cols,
    input  wire [DIM_WIDTH-1:0]  i_rows,
    output logic                 o_last
);

    logic [DIM_WIDTH-1:0] r_col;
    logic [DIM_WIDTH-1:0] r_row;
    logic [DIM_WIDTH-1:0] n_col;
    logic [DIM_WIDTH-1:0] n_row;
    logic [DIM_WIDTH:0]   col_inc;
    logic [DIM_WIDTH:0]   row_inc;

    // compare one bit wider so a count at the top of its range never matches
    assign col_inc = {1'b0, r_col} + {{DIM_WIDTH{1'b0}}, 1'b1};
    assign row_inc = {1'b0, r_row} + {{DIM_WIDTH{1'b0}}, 1'b1};
    assign o_last  = (col_inc == {1'b0, i_cols}) && (row_inc == {1'b0, i_rows});

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_clear) begin
            n_col = '0;
            n_row = '0;
        end else if (i_step) begin
            if (col_inc[DIM_WIDTH-1:0] == i_cols) begin
                n_col = '0;
                n_row = row_inc[DIM_WIDTH-1:0];
            end else begin
                n_col = col_inc[DIM_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule
`default_nettype wire

[rtl/core/terrain_file_stream_parser.sv]
// top level: byte-stream parser for heightfield terrain files
//
//  channel  dir  payload                                      transfer when
//  i_in     in   in_byte, first_byte                          valid && ready
//  o_out    out  kind, code, cols, rows, scale, base, sample  valid && ready
//
// one file byte per cycle sustained while the output is not stalled; a byte is
// caught in an input register, decoded combinationally against the parse state,
// and its result, if any, is written to the output register as the decode step runs
// input and output registers decouple the sides, so a byte is taken while a
// result still waits; the pipe holds only while the output register is full
// and not drained
// reset is synchronous and active low; first_byte restarts the parse at once
`default_nettype none
module terrain_file_stream_parser
    import tfsp_pkg::*;
#(
    parameter int DIM_WIDTH = 17
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tfsp_in_if.sink     i_in,
    tfsp_out_if.source  o_out
);

    // parse phases
    localparam logic [3:0] PH_NAME     = 4'd0;
    localparam logic [3:0] PH_TYPE     = 4'd1;
    localparam logic [3:0] PH_TYPE_BAD = 4'd2;
    localparam logic [3:0] PH_SEG0     = 4'd3;
    localparam logic [3:0] PH_SEG1     = 4'd4;
    localparam logic [3:0] PH_SEGY     = 4'd5;
    localparam logic [3:0] PH_SEGA     = 4'd6;
    localparam logic [3:0] PH_SIZE     = 4'd7;
    localparam logic [3:0] PH_XPTS     = 4'd8;
    localparam logic [3:0] PH_YPTS     = 4'd9;
    localparam logic [3:0] PH_ALTW     = 4'd10;
    localparam logic [3:0] PH_DATA     = 4'd11;
    localparam logic [3:0] PH_IDLE     = 4'd12;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_first;

    // parse state
    logic [3:0]           r_phase,  n_phase;
    logic [3:0]           r_idx,    n_idx;
    logic [63:0]          r_tag,    n_tag;
    logic [DIM_WIDTH-1:0] r_cols,   n_cols;
    logic [DIM_WIDTH-1:0] r_rows,   n_rows;
    logic [BYTE_W-1:0]    r_hold,   n_hold;

    // output register
    logic                     r_out_valid;
    logic [KIND_W-1:0]        r_kind,   n_kind;
    logic [CODE_W-1:0]        r_code,   n_code;
    logic [MAP_W-1:0]         r_mcols,  n_mcols;
    logic [MAP_W-1:0]         r_mrows,  n_mrows;
    logic [WORD_W-1:0]        r_scale,  n_scale;
    logic [WORD_W-1:0]        r_base,   n_base;
    logic [WORD_W-1:0]        r_sample, n_sample;
    logic                     r_last,   n_last;
    logic                     n_res;

    // decode
    logic                 advance;
    logic [3:0]           e_phase;
    logic [3:0]           e_idx;
    logic [63:0]          e_tag;
    logic [DIM_WIDTH-1:0] e_cols;
    logic [DIM_WIDTH-1:0] e_rows;
    logic [63:0]          tag_next;
    logic [3:0]           idx_next;
    logic [3:0]           need;
    logic                 tag_done;
    logic [31:0]          seg_tag;
    logic [WORD_W-1:0]    w0;
    logic [WORD_W-1:0]    w1;
    logic [MAP_W-1:0]     w0_ext;
    logic [MAP_W-1:0]     w0_plus1;
    logic                 ctr_clear;
    logic                 ctr_step;
    logic                 ctr_last;

    // the decode step runs when the output register can take its result
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // a first byte restarts from the reset state before it is decoded
    assign e_phase = r_in_first ? PH_NAME : r_phase;
    assign e_idx   = r_in_first ? 4'd0    : r_idx;
    assign e_tag   = r_in_first ? 64'd0   : r_tag;
    assign e_cols  = r_in_first ? '0      : r_cols;
    assign e_rows  = r_in_first ? '0      : r_rows;

    assign tag_next = {e_tag[55:0], r_in_byte};
    assign idx_next = e_idx + 4'd1;
    assign need     = (e_phase <= PH_TYPE_BAD) ? 4'd8 : 4'd4;
    assign tag_done = (idx_next >= need);
    assign seg_tag  = tag_next[31:0];
    // little-endian words out of the four body bytes, oldest byte lowest
    assign w0       = {seg_tag[23:16], seg_tag[31:24]};
    assign w1       = {seg_tag[7:0],   seg_tag[15:8]};
    assign w0_ext   = {1'b0, w0};
    assign w0_plus1 = w0_ext + 17'd1;

    tfsp_sample_ctr #(
        .DIM_WIDTH (DIM_WIDTH)
    ) u_sample_ctr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (ctr_clear),
        .i_step  (ctr_step),
        .i_cols  (r_cols),
        .i_rows  (r_rows),
        .o_last  (ctr_last)
    );

    always_comb begin
        n_phase   = e_phase;
        n_idx     = e_idx;
        n_tag     = e_tag;
        n_cols    = e_cols;
        n_rows    = e_rows;
        n_hold    = r_hold;
        n_res     = 1'b0;
        n_kind    = KIND_HEADER;
        n_code    = ERR_NONE;
        n_mcols   = '0;
        n_mrows   = '0;
        n_scale   = '0;
        n_base    = '0;
        n_sample  = '0;
        n_last    = 1'b0;
        ctr_clear = 1'b0;
        ctr_step  = 1'b0;

        if (e_phase == PH_DATA) begin
            if (e_idx == 4'd0) begin
                n_hold = r_in_byte;
                n_idx  = 4'd1;
            end else begin
                n_idx    = 4'd0;
                n_res    = 1'b1;
                n_kind   = KIND_SAMPLE;
                n_sample = {r_in_byte, r_hold};
                n_last   = ctr_last;
                ctr_step = advance;
                if (ctr_last) begin
                    n_phase = PH_IDLE;
                    n_tag   = '0;
                end
            end
        end else if (e_phase < PH_IDLE) begin
            n_tag = tag_next;
            n_idx = idx_next;
            if (tag_done) begin
                // every completed tag or body starts the next phase afresh
                n_idx   = 4'd0;
                n_tag   = '0;
                n_phase = PH_IDLE;
                case (e_phase)
                    PH_NAME: begin
                        n_phase = (tag_next == TAG_NAME) ? PH_TYPE : PH_TYPE_BAD;
                    end
                    PH_TYPE: begin
                        if (tag_next == TAG_TYPE) begin
                            n_phase = PH_SEG0;
                        end else begin
                            n_res  = 1'b1;
                            n_kind = KIND_ERROR;
                            n_code = ERR_BAD_NAME;
                        end
                    end
                    PH_TYPE_BAD: begin
                        n_res  = 1'b1;
                        n_kind = KIND_ERROR;
                        n_code = ERR_BAD_NAME;
                    end
                    PH_SEG0, PH_SEG1, PH_SEGA: begin
                        if (e_phase == PH_SEG0 && seg_tag == TAG_SIZE) begin
                            n_phase = PH_SIZE;
                        end else if (e_phase != PH_SEGA && seg_tag == TAG_XPTS) begin
                            n_phase = PH_XPTS;
                        end else if (seg_tag == TAG_ALTW) begin
                            n_phase = PH_ALTW;
                        end else begin
                            // an unknown or out-of-place segment counts as a missing ALTW
                            n_res  = 1'b1;
                            n_kind = KIND_ERROR;
                            n_code = ERR_NO_ALTW;
                        end
                    end
                    PH_SEGY: begin
                        if (seg_tag == TAG_YPTS) begin
                            n_phase = PH_YPTS;
                        end else begin
                            n_res  = 1'b1;
                            n_kind = KIND_ERROR;
                            n_code = ERR_NO_YPTS;
                        end
                    end
                    PH_SIZE: begin
                        n_cols  = w0_plus1[DIM_WIDTH-1:0];
                        n_rows  = w0_plus1[DIM_WIDTH-1:0];
                        n_phase = PH_SEG1;
                    end
                    PH_XPTS: begin
                        n_cols  = w0_ext[DIM_WIDTH-1:0];
                        n_phase = PH_SEGY;
                    end
                    PH_YPTS: begin
                        n_rows  = w0_ext[DIM_WIDTH-1:0];
                        n_phase = PH_SEGA;
                    end
                    PH_ALTW: begin
                        n_res     = 1'b1;
                        n_kind    = KIND_HEADER;
                        n_mcols[DIM_WIDTH-1:0] = e_cols;
                        n_mrows[DIM_WIDTH-1:0] = e_rows;
                        n_scale   = w0;
                        n_base    = w1;
                        ctr_clear = advance;
                        // an empty map gives the header and nothing else
                        n_phase   = (e_cols != '0 && e_rows != '0) ? PH_DATA : PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte  <= i_in.in_byte;
            r_in_first <= i_in.first_byte;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NAME;
            r_idx   <= 4'd0;
            r_tag   <= '0;
            r_cols  <= '0;
            r_rows  <= '0;
            r_hold  <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_tag   <= n_tag;
            r_cols  <= n_cols;
            r_rows  <= n_rows;
            r_hold  <= n_hold;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_res;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_res) begin
            r_kind   <= n_kind;
            r_code   <= n_code;
            r_mcols  <= n_mcols;
            r_mrows  <= n_mrows;
            r_scale  <= n_scale;
            r_base   <= n_base;
            r_sample <= n_sample;
            r_last   <= n_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_kind      = r_kind;
    assign o_out.error_code    = r_code;
    assign o_out.map_cols      = r_mcols;
    assign o_out.map_rows      = r_mrows;
    assign o_out.height_scale  = r_scale;
    assign o_out.base_height   = r_base;
    assign o_out.height_sample = r_sample;
    assign o_out.last_sample   = r_last;

endmodule
`default_nettype wire

[tb/sv/tb_terrain_file_stream_parser.sv]
// testbench of the terrain file stream parser: byte-level parse predictor and result scoreboard
module tb_terrain_file_stream_parser;
    import tfsp_pkg::*;

    localparam int          DIM_W        = 17;
    localparam int unsigned DIM_MASK     = (1 << DIM_W) - 1;
    localparam int          TOTAL_BYTES  = 750;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          MAX_PRINTS   = 40;

    // where the parse stands between bytes
    typedef enum logic [3:0] {
        PH_NAME, PH_TYPE, PH_TYPE_BAD, PH_SEG0, PH_SEG1, PH_SEGY, PH_SEGA,
        PH_SIZE, PH_XPTS, PH_YPTS, PH_ALTW, PH_DATA, PH_IDLE
    } t_phase;

    typedef struct packed {
        logic [KIND_W-1:0] out_kind;
        logic [CODE_W-1:0] error_code;
        logic [MAP_W-1:0]  map_cols;
        logic [MAP_W-1:0]  map_rows;
        logic [WORD_W-1:0] height_scale;
        logic [WORD_W-1:0] base_height;
        logic [WORD_W-1:0] height_sample;
        logic              last_sample;
    } t_result;

    // follows the file parse byte by byte and holds the results still due
    class parse_tracker;
        t_phase       phase;
        logic [3:0]   idx;
        logic [63:0]  shift;
        int unsigned  cols, rows, row_cnt, col_cnt;
        logic [15:0]  scale, base;
        logic [7:0]   low_hold;
        t_result      due_q[$];
        int unsigned  fails, headers, samples, errs, bytes_used;

        function new();
            restart();
        endfunction

        function void enter_phase(t_phase ph);
            phase = ph;
            idx   = 4'd0;
            shift = 64'd0;
        endfunction

        function void restart();
            enter_phase(PH_NAME);
            cols     = 0;
            rows     = 0;
            scale    = 16'd0;
            base     = 16'd0;
            low_hold = 8'd0;
            row_cnt  = 0;
            col_cnt  = 0;
        endfunction

        function void post(logic [KIND_W-1:0] k, logic [CODE_W-1:0] c, int unsigned mc,
                           int unsigned mr, logic [15:0] sc, logic [15:0] bs,
                           logic [15:0] smp, logic lst);
            t_result r;
            r.out_kind      = k;
            r.error_code    = c;
            r.map_cols      = mc[MAP_W-1:0];
            r.map_rows      = mr[MAP_W-1:0];
            r.height_scale  = sc;
            r.base_height   = bs;
            r.height_sample = smp;
            r.last_sample   = lst;
            due_q.push_back(r);
        endfunction

        function void abort(logic [CODE_W-1:0] c);
            enter_phase(PH_IDLE);
            post(KIND_ERROR, c, 0, 0, 16'd0, 16'd0, 16'd0, 1'b0);
        endfunction

        function void take_segment(logic [31:0] t, bit size_ok, bit xpts_ok);
            if (size_ok && t == TAG_SIZE) begin
                enter_phase(PH_SIZE);
            end else if (xpts_ok && t == TAG_XPTS) begin
                enter_phase(PH_XPTS);
            end else if (t == TAG_ALTW) begin
                enter_phase(PH_ALTW);
            end else begin
                abort(ERR_NO_ALTW);
            end
        endfunction

        function void parse_byte(logic [7:0] b, logic first);
            logic [31:0] t;
            logic [15:0] w0, w1, smp;
            logic        is_last;
            int unsigned need;
            if (first) restart();
            // done or failed: everything waits for the next file start
            if (phase == PH_IDLE) return;
            bytes_used++;
            if (phase == PH_DATA) begin
                if (idx == 4'd0) begin
                    low_hold = b;
                    idx      = 4'd1;
                    return;
                end
                idx     = 4'd0;
                smp     = {b, low_hold};
                is_last = (col_cnt + 1 == cols) && (row_cnt + 1 == rows);
                col_cnt = (col_cnt + 1) & DIM_MASK;
                if (col_cnt == cols) begin
                    col_cnt = 0;
                    row_cnt = (row_cnt + 1) & DIM_MASK;
                end
                if (is_last) enter_phase(PH_IDLE);
                post(KIND_SAMPLE, ERR_NONE, 0, 0, 16'd0, 16'd0, smp, is_last);
                return;
            end
            shift = {shift[55:0], b};
            idx   = idx + 4'd1;
            need  = (phase <= PH_TYPE_BAD) ? 8 : 4;
            if (idx < need) return;
            // little-endian words out of the last four bytes
            t  = shift[31:0];
            w0 = {t[23:16], t[31:24]};
            w1 = {t[7:0], t[15:8]};
            case (phase)
                PH_NAME: begin
                    enter_phase((shift == TAG_NAME) ? PH_TYPE : PH_TYPE_BAD);
                end
                PH_TYPE: begin
                    if (shift != TAG_TYPE) abort(ERR_BAD_NAME);
                    else enter_phase(PH_SEG0);
                end
                PH_TYPE_BAD: abort(ERR_BAD_NAME);
                PH_SEG0: take_segment(t, 1'b1, 1'b1);
                PH_SEG1: take_segment(t, 1'b0, 1'b1);
                PH_SEGY: begin
                    if (t != TAG_YPTS) abort(ERR_NO_YPTS);
                    else enter_phase(PH_YPTS);
                end
                PH_SEGA: take_segment(t, 1'b0, 1'b0);
                PH_SIZE: begin
                    cols = (32'(w0) + 1) & DIM_MASK;
                    rows = cols;
                    enter_phase(PH_SEG1);
                end
                PH_XPTS: begin
                    cols = 32'(w0) & DIM_MASK;
                    enter_phase(PH_SEGY);
                end
                PH_YPTS: begin
                    rows = 32'(w0) & DIM_MASK;
                    enter_phase(PH_SEGA);
                end
                PH_ALTW: begin
                    scale   = w0;
                    base    = w1;
                    row_cnt = 0;
                    col_cnt = 0;
                    enter_phase((cols != 0 && rows != 0) ? PH_DATA : PH_IDLE);
                    post(KIND_HEADER, ERR_NONE, cols, rows, scale, base, 16'd0, 1'b0);
                end
                default: enter_phase(PH_IDLE);
            endcase
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            fails++;
            if (fails <= MAX_PRINTS)
                $display("[%0t] check failed: %s got %0h want %0h", $time, what, got, want);
        endtask

        task check_result(t_result got);
            t_result want;
            if (due_q.size() == 0) begin
                report("result with none due, out_kind", got.out_kind, 0);
                return;
            end
            want = due_q.pop_front();
            if (got.out_kind !== want.out_kind)
                report("out_kind", got.out_kind, want.out_kind);
            if (got.error_code !== want.error_code)
                report("error_code", got.error_code, want.error_code);
            if (got.map_cols !== want.map_cols)
                report("map_cols", got.map_cols, want.map_cols);
            if (got.map_rows !== want.map_rows)
                report("map_rows", got.map_rows, want.map_rows);
            if (got.height_scale !== want.height_scale)
                report("height_scale", got.height_scale, want.height_scale);
            if (got.base_height !== want.base_height)
                report("base_height", got.base_height, want.base_height);
            if (got.height_sample !== want.height_sample)
                report("height_sample", got.height_sample, want.height_sample);
            if (got.last_sample !== want.last_sample)
                report("last_sample", got.last_sample, want.last_sample);
            case (want.out_kind)
                KIND_HEADER: headers++;
                KIND_SAMPLE: samples++;
                default:     errs++;
            endcase
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    tfsp_in_if  in_if ();
    tfsp_out_if out_if ();

    terrain_file_stream_parser #(.DIM_WIDTH(DIM_W)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    parse_tracker tracker;
    logic [8:0]   file_q[$];    // {first_byte, in_byte} of the file being built
    logic         file_open;    // next byte put is the first of a file
    int           burst_left;
    int           files_sent;
    int           bytes_sent;
    int           cycles;
    bit           hold_req;
    bit           draining;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a stuck handshake ends the run
    initial begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("terrain_file_stream_parser: mismatch");
        $finish;
    end

    // file building
    function automatic void put_byte(logic [7:0] b);
        file_q.push_back({file_open, b});
        file_open = 1'b0;
    endfunction

    function automatic void put_word(logic [15:0] w);
        put_byte(w[7:0]);
        put_byte(w[15:8]);
    endfunction

    function automatic void put_tag(logic [31:0] tag);
        for (int i = 3; i >= 0; i--) put_byte(tag[i*8 +: 8]);
    endfunction

    function automatic void put_head(logic [63:0] nm, logic [63:0] ty);
        for (int i = 7; i >= 0; i--) put_byte(nm[i*8 +: 8]);
        for (int i = 7; i >= 0; i--) put_byte(ty[i*8 +: 8]);
    endfunction

    // dimension segment: value word plus two pad bytes
    function automatic void put_dim(logic [31:0] tag, logic [15:0] w);
        put_tag(tag);
        put_word(w);
        put_word(16'($urandom));
    endfunction

    function automatic void put_altw(logic [15:0] sc, logic [15:0] bs);
        put_tag(TAG_ALTW);
        put_word(sc);
        put_word(bs);
    endfunction

    function automatic void put_noise(int n);
        for (int i = 0; i < n; i++) put_byte(8'($urandom));
    endfunction

    // mostly small dimensions, now and then any 16-bit value
    function automatic logic [15:0] pick_dim(int top);
        return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, top));
    endfunction

    // one byte through the input handshake; bursts of random length, random gaps
    task automatic send_byte(logic [7:0] b, logic first);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid      <= 1'b1;
        in_if.in_byte    <= b;
        in_if.first_byte <= first;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        bytes_sent++;
        tracker.parse_byte(b, first);
    endtask

    task automatic play_file();
        foreach (file_q[i]) send_byte(file_q[i][7:0], file_q[i][8]);
        file_q.delete();
        files_sent++;
    endtask

    task automatic play_random_file();
        int          pick, form, pos;
        longint      mcols, mrows, nbytes;
        logic [15:0] w;
        file_open = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            // well-formed file with random content
            put_head(TAG_NAME, TAG_TYPE);
            form  = $urandom_range(0, 3);
            mcols = 0;
            mrows = 0;
            if (form == 1 || form == 3) begin
                w = pick_dim(4);
                put_dim(TAG_SIZE, w);
                mcols = longint'(w) + 1;
                mrows = mcols;
            end
            if (form >= 2) begin
                w = pick_dim(6);
                put_dim(TAG_XPTS, w);
                mcols = w;
                w = pick_dim(6);
                put_dim(TAG_YPTS, w);
                mrows = w;
            end
            put_altw(16'($urandom), 16'($urandom));
            nbytes = 2 * mcols * mrows;
            // big maps are cut short, some small ones too
            if (nbytes > 128) nbytes = $urandom_range(0, 40);
            else if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(0, int'(nbytes));
            put_noise(int'(nbytes));
            if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 6));
        end else if (pick < 75) begin
            // one flipped bit somewhere in the name or type
            put_head(TAG_NAME, TAG_TYPE);
            pos = $urandom_range(0, 15);
            file_q[pos] = file_q[pos] ^ (9'd1 << $urandom_range(0, 7));
            put_altw(16'($urandom), 16'($urandom));
        end else if (pick < 83) begin
            // random or SIZE segment tag after zero to three good segments
            put_head(TAG_NAME, TAG_TYPE);
            if ($urandom_range(0, 1) == 1) put_dim(TAG_SIZE, pick_dim(4));
            if ($urandom_range(0, 2) == 0) begin
                put_dim(TAG_XPTS, pick_dim(6));
                put_dim(TAG_YPTS, pick_dim(6));
            end
            if ($urandom_range(0, 1) == 1) put_tag(32'($urandom));
            else put_tag(TAG_SIZE);
            put_noise(4);
        end else if (pick < 90) begin
            // XPTS with no YPTS behind it
            put_head(TAG_NAME, TAG_TYPE);
            if ($urandom_range(0, 1) == 1) put_dim(TAG_SIZE, pick_dim(4));
            put_dim(TAG_XPTS, pick_dim(6));
            case ($urandom_range(0, 2))
                0:       put_tag(TAG_ALTW);
                1:       put_tag(TAG_XPTS);
                default: put_tag(32'($urandom));
            endcase
            put_noise(4);
        end else begin
            // noise with stray restarts
            for (int i = $urandom_range(1, 24); i > 0; i--) begin
                put_byte(8'($urandom));
                file_open = ($urandom_range(0, 7) == 0);
            end
        end
        play_file();
    endtask

    // receiver: stall patterns change at random intervals, plus one long hold-off
    initial begin
        t_result      got;
        int           mode, mode_left, hold_left;
        bit           hold_done;
        out_if.ready <= 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.out_kind      = out_if.out_kind;
                got.error_code    = out_if.error_code;
                got.map_cols      = out_if.map_cols;
                got.map_rows      = out_if.map_rows;
                got.height_scale  = out_if.height_scale;
                got.base_height   = out_if.base_height;
                got.height_sample = out_if.height_sample;
                got.last_sample   = out_if.last_sample;
                tracker.check_result(got);
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (draining) begin
                out_if.ready <= 1'b1;
            end else if (hold_left > 0) begin
                // long hold-off fills the pipe and stalls the sender
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= 1'($urandom_range(0, 1));
                    2:       out_if.ready <= ($urandom_range(0, 3) == 0);
                    default: out_if.ready <= (mode_left[1:0] != 2'd0);
                endcase
            end
        end
    end

    // stimulus and end of run
    initial begin
        int          waited;
        tracker    = new();
        file_q.delete();
        file_open  = 1'b0;
        burst_left = 0;
        files_sent = 0;
        bytes_sent = 0;
        hold_req   = 1'b0;
        draining   = 1'b0;
        in_if.valid      <= 1'b0;
        in_if.in_byte    <= 8'd0;
        in_if.first_byte <= 1'b0;
        i_rst_n          <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bad name: type bytes still consumed, trailing byte ignored
        file_open = 1'b1;
        put_head(TAG_NAME ^ 64'h01, TAG_TYPE);
        put_byte(8'h00);
        play_file();
        // bad type
        file_open = 1'b1;
        put_head(TAG_NAME, TAG_TYPE ^ 64'h8000_0000_0000_0000);
        play_file();
        // unknown first segment reads as missing ALTW
        file_open = 1'b1;
        put_head(TAG_NAME, TAG_TYPE);
        put_tag(32'h4142_4344);
        play_file();
        // XPTS then ALTW: YPTS missing
        file_open = 1'b1;
        put_head(TAG_NAME, TAG_TYPE);
        put_dim(TAG_XPTS, 16'd3);
        put_tag(TAG_ALTW);
        play_file();
        // no size at all: 0 by 0 header, nothing after
        file_open = 1'b1;
        put_head(TAG_NAME, TAG_TYPE);
        put_altw(16'hFFFF, 16'hFFFF);
        put_byte(8'hFF);
        play_file();
        // 2 by 2 map with sample extremes, trailing byte ignored
        file_open = 1'b1;
        put_head(TAG_NAME, TAG_TYPE);
        put_dim(TAG_SIZE, 16'd1);
        put_altw(16'h0000, 16'h0000);
        put_word(16'h8000);
        put_word(16'h7FFF);
        put_word(16'hFFFF);
        put_word(16'h0000);
        put_byte(8'hA5);
        play_file();
        // widest columns, zero rows: header only
        file_open = 1'b1;
        put_head(TAG_NAME, TAG_TYPE);
        put_dim(TAG_XPTS, 16'hFFFF);
        put_dim(TAG_YPTS, 16'h0000);
        put_altw(16'h8000, 16'h0001);
        play_file();
        // largest square map, cut short by the next file start
        file_open = 1'b1;
        put_head(TAG_NAME, TAG_TYPE);
        put_dim(TAG_SIZE, 16'hFFFF);
        put_altw(16'h0001, 16'h8000);
        put_noise(6);
        play_file();
        // SIZE overridden by XPTS and YPTS
        file_open = 1'b1;
        put_head(TAG_NAME, TAG_TYPE);
        put_dim(TAG_SIZE, 16'd0);
        put_dim(TAG_XPTS, 16'd2);
        put_dim(TAG_YPTS, 16'd1);
        put_altw(16'h1234, 16'h5678);
        put_noise(4);
        play_file();
        // a second SIZE is not accepted
        file_open = 1'b1;
        put_head(TAG_NAME, TAG_TYPE);
        put_dim(TAG_SIZE, 16'd2);
        put_tag(TAG_SIZE);
        play_file();

        // random part, opened by the long receiver hold-off
        hold_req = 1'b1;
        while (bytes_sent < TOTAL_BYTES) play_random_file();

        in_if.valid <= 1'b0;
        draining = 1'b1;
        waited   = 0;
        while (tracker.due_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        foreach (tracker.due_q[i])
            tracker.report("result never came, out_kind", 0, tracker.due_q[i].out_kind);

        $display("covered %0d files, %0d bytes sent, %0d parsed: %0d headers, %0d samples, %0d errors",
                 files_sent, bytes_sent, tracker.bytes_used, tracker.headers,
                 tracker.samples, tracker.errs);
        $display("receiver held off %0d cycles once; %0d field checks failed",
                 HOLD_CYCLES, tracker.fails);
        if (tracker.fails == 0) begin
            $display("terrain_file_stream_parser: match");
        end else begin
            $display("terrain_file_stream_parser: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/tfsp_pkg.sv
rtl/core/tfsp_in_if.sv
rtl/core/tfsp_out_if.sv
rtl/core/tfsp_sample_ctr.sv
rtl/core/terrain_file_stream_parser.sv
tb/sv/tb_terrain_file_stream_parser.sv
